// ===== hdl/cac_pkg.sv =====
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types and constants for the car alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int FLASH_W         = 4;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;

    typedef enum logic [2:0] {
        MODE_ARMED    = 3'd0,
        MODE_ENTRY    = 3'd1,
        MODE_ALARM    = 3'd2,
        MODE_DISARMED = 3'd3,
        MODE_PROTECT  = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_LED_ON       = 4'd1,
        PH_LED_OFF      = 4'd2,
        PH_LOCATE       = 4'd3,
        PH_WAIT         = 4'd4,
        PH_CALL         = 4'd5,
        PH_FLASH_ON     = 4'd6,
        PH_FLASH_OFF    = 4'd7,
        PH_HANGUP       = 4'd8,
        PH_CHIRP_ARM    = 4'd9,
        PH_CHIRP_DISARM = 4'd10
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_DELAY = 3'd0,
        CFG_FLASH_HALF  = 3'd1,
        CFG_FLASH_COUNT = 3'd2,
        CFG_CHIRP       = 3'd3,
        CFG_BLINK_ON    = 3'd4,
        CFG_BLINK_OFF   = 3'd5,
        CFG_LOCATE      = 3'd6,
        CFG_GSM_PULSE   = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0]   RST_ENTRY_DELAY = 16'd400;
    localparam logic [CFG_W-1:0]   RST_FLASH_HALF  = 16'd50;
    localparam logic [FLASH_W-1:0] RST_FLASH_COUNT = 4'd10;
    localparam logic [CFG_W-1:0]   RST_CHIRP       = 16'd20;
    localparam logic [CFG_W-1:0]   RST_BLINK_ON    = 16'd10;
    localparam logic [CFG_W-1:0]   RST_BLINK_OFF   = 16'd50;
    localparam logic [CFG_W-1:0]   RST_LOCATE      = 16'd10;
    localparam logic [CFG_W-1:0]   RST_GSM_PULSE   = 16'd2;

    typedef struct packed {
        logic [CFG_W-1:0]   gsm_pulse_ticks;
        logic [CFG_W-1:0]   locate_ticks;
        logic [CFG_W-1:0]   blink_off_ticks;
        logic [CFG_W-1:0]   blink_on_ticks;
        logic [CFG_W-1:0]   chirp_ticks;
        logic [FLASH_W-1:0] alarm_flash_count;
        logic [CFG_W-1:0]   flash_half_ticks;
        logic [CFG_W-1:0]   entry_delay_ticks;
    } t_cfg;

    // last field in the lowest bit
    typedef struct packed {
        logic remote_disarm;
        logic remote_arm;
        logic remote_locate;
        logic remote_cancel;
        logic protect_switch;
        logic valet_pressed;
        logic ignition_on;
        logic hood_open;
        logic other_door_open;
        logic trunk_open;
        logic driver_door_open;
    } t_in_item;

    typedef struct packed {
        t_mode alarm_mode;
        logic  hood_light;
        logic  trunk_light;
        logic  dome_light;
        logic  status_led;
        logic  gsm_hangup;
        logic  gsm_call;
        logic  power_enable;
        logic  high_beams;
        logic  parking_lights;
        logic  horn;
    } t_out_item;

    localparam int IN_ITEM_W  = $bits(t_in_item);
    localparam int OUT_ITEM_W = $bits(t_out_item);

endpackage

`default_nettype wire

// ===== hdl/car_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// car_alarm_controller_unit
// Vehicle alarm sequencer: one sampled-switch request per timer tick in,
// one output pin image per tick out.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tick: switch lines
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | pin image and mode
//  cfg       | in        | i_cfg_we (no wait)           | register index, data
//
//  For each request the next state and the pin image are worked out in one
//  pass from the state registers and the request, and the image
//  lands in the output register on the accept edge. A request can be taken
//  in every cycle while the output register is empty or being drained, so
//  the rate is one tick per cycle; only a stalled m_axis holds s_axis_tready
//  low. Reset (i_rst_n low, synchronous) puts the block in armed mode with
//  no phase running, loads the default timings and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module car_alarm_controller_unit
    import cac_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [0] driver_door_open [1] trunk_open [2] other_door_open [3] hood_open
    // [4] ignition_on [5] valet_pressed [6] protect_switch [7] remote_cancel
    // [8] remote_locate [9] remote_arm [10] remote_disarm, rest zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] horn [1] parking_lights [2] high_beams [3] power_enable
    // [4] gsm_call [5] gsm_hangup [6] status_led [7] dome_light
    // [8] trunk_light [9] hood_light [12:10] alarm_mode, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg      cfg;
    t_in_item  in_item;
    t_out_item image;
    logic      accept;

    logic                   r_out_valid;
    logic [OUT_ITEM_W-1:0]  r_out_image;

    assign in_item       = t_in_item'(s_axis_tdata[IN_ITEM_W-1:0]);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cac_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (in_item),
        .i_cfg   (cfg),
        .o_image (image)
    );

    // output register: filled on accept, drained by the downstream side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_image <= image;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_image);

endmodule

`default_nettype wire

// ===== hdl/cac_cfg.sv =====
// ----------------------------------------------------------------------------
// cac_cfg
// Configuration register bank, write only, reset to the default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_cfg
    import cac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [CFG_IDX_W-1:0] i_addr,
    input  wire logic [CFG_W-1:0]     i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_delay_ticks <= RST_ENTRY_DELAY;
            r_cfg.flash_half_ticks  <= RST_FLASH_HALF;
            r_cfg.alarm_flash_count <= RST_FLASH_COUNT;
            r_cfg.chirp_ticks       <= RST_CHIRP;
            r_cfg.blink_on_ticks    <= RST_BLINK_ON;
            r_cfg.blink_off_ticks   <= RST_BLINK_OFF;
            r_cfg.locate_ticks      <= RST_LOCATE;
            r_cfg.gsm_pulse_ticks   <= RST_GSM_PULSE;
        end else if (i_we) begin
            case (t_cfg_idx'(i_addr))
                CFG_ENTRY_DELAY: r_cfg.entry_delay_ticks <= i_data;
                CFG_FLASH_HALF:  r_cfg.flash_half_ticks  <= i_data;
                CFG_FLASH_COUNT: r_cfg.alarm_flash_count <= i_data[FLASH_W-1:0];
                CFG_CHIRP:       r_cfg.chirp_ticks       <= i_data;
                CFG_BLINK_ON:    r_cfg.blink_on_ticks    <= i_data;
                CFG_BLINK_OFF:   r_cfg.blink_off_ticks   <= i_data;
                CFG_LOCATE:      r_cfg.locate_ticks      <= i_data;
                CFG_GSM_PULSE:   r_cfg.gsm_pulse_ticks   <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/cac_seq.sv =====
// ----------------------------------------------------------------------------
// cac_seq
// Alarm sequencer: mode, phase, tick timer and flash counter, one tick per
// step, plus the output pin image for that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_seq
    import cac_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_out_item     o_image
);

    t_mode                  r_mode,  n_mode;
    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic [FLASH_W-1:0]     r_flash, n_flash;

    logic any_open;
    logic any_chg;
    logic do_armed;
    logic do_decide;
    logic do_disarmed;
    logic [FLASH_W-1:0] flash_inc;

    assign any_open  = i_item.driver_door_open | i_item.trunk_open
                     | i_item.other_door_open | i_item.hood_open;
    assign any_chg   = any_open | i_item.ignition_on;
    assign flash_inc = r_flash + FLASH_W'(1);

    // lengths are taken to the timer width (truncate or zero extend)
    function automatic logic [TIMER_WIDTH-1:0] len(input logic [CFG_W-1:0] ticks);
        return TIMER_WIDTH'(ticks);
    endfunction

    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_flash     = r_flash;
        do_armed    = 1'b0;
        do_decide   = 1'b0;
        do_disarmed = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (r_mode == MODE_DISARMED) do_disarmed = 1'b1;
            else                         do_armed    = 1'b1;
        end else if (r_timer > TIMER_WIDTH'(1)) begin
            n_timer = r_timer - TIMER_WIDTH'(1);
        end else begin
            n_timer = '0;
            case (r_phase)
                PH_LED_ON: begin
                    n_phase = PH_LED_OFF;
                    n_timer = len(i_cfg.blink_off_ticks);
                end
                PH_LED_OFF: begin
                    if (i_item.remote_locate) begin
                        n_phase = PH_LOCATE;
                        n_timer = len(i_cfg.locate_ticks);
                    end else begin
                        do_armed = 1'b1;
                    end
                end
                PH_WAIT: do_decide = 1'b1;
                PH_CALL: begin
                    n_phase = PH_FLASH_ON;
                    n_timer = len(i_cfg.flash_half_ticks);
                end
                PH_FLASH_ON: begin
                    n_phase = PH_FLASH_OFF;
                    n_timer = len(i_cfg.flash_half_ticks);
                end
                PH_FLASH_OFF: begin
                    if (r_mode == MODE_PROTECT) begin
                        if (i_item.valet_pressed) begin
                            do_disarmed = 1'b1;
                        end else begin
                            n_phase = PH_FLASH_ON;
                            n_timer = len(i_cfg.flash_half_ticks);
                        end
                    end else begin
                        n_flash = flash_inc;
                        if (flash_inc == i_cfg.alarm_flash_count) begin
                            n_phase = PH_HANGUP;
                            n_timer = len(i_cfg.gsm_pulse_ticks);
                        end else begin
                            do_decide = 1'b1;
                        end
                    end
                end
                PH_HANGUP: begin
                    n_flash = '0;
                    if (any_chg) begin
                        n_phase = PH_CALL;
                        n_timer = len(i_cfg.gsm_pulse_ticks);
                    end else begin
                        n_phase = PH_CHIRP_ARM;
                        n_timer = len(i_cfg.chirp_ticks);
                    end
                end
                PH_CHIRP_DISARM: do_disarmed = 1'b1;
                default:         do_armed    = 1'b1;  // locate end, chirp to armed
            endcase
        end

        // armed check; may fall through into the alarm decision below
        if (do_armed) begin
            n_mode  = MODE_ARMED;
            n_flash = '0;
            if (any_chg) begin
                if (i_item.driver_door_open) begin
                    n_mode  = MODE_ENTRY;
                    n_phase = PH_WAIT;
                    n_timer = len(i_cfg.entry_delay_ticks);
                end else begin
                    do_decide = 1'b1;
                end
            end else if (i_item.remote_disarm) begin
                n_phase = PH_CHIRP_DISARM;
                n_timer = len(i_cfg.chirp_ticks);
            end else begin
                n_phase = PH_LED_ON;
                n_timer = len(i_cfg.blink_on_ticks);
            end
        end

        // alarm decision: valet, then cancel, then a new call and flash
        if (do_decide) begin
            if (i_item.valet_pressed) begin
                n_phase = PH_CHIRP_DISARM;
                n_timer = len(i_cfg.chirp_ticks);
            end else if (i_item.remote_cancel) begin
                n_phase = PH_CHIRP_ARM;
                n_timer = len(i_cfg.chirp_ticks);
            end else begin
                if (n_mode != MODE_ALARM) n_flash = '0;
                n_mode  = MODE_ALARM;
                n_phase = PH_CALL;
                n_timer = len(i_cfg.gsm_pulse_ticks);
            end
        end

        if (do_disarmed) begin
            n_mode  = MODE_DISARMED;
            n_phase = PH_IDLE;
            n_timer = '0;
            if (i_item.protect_switch) begin
                if (any_open) begin
                    n_mode  = MODE_PROTECT;
                    n_phase = PH_FLASH_ON;
                    n_timer = len(i_cfg.flash_half_ticks);
                end
            end else if (i_item.remote_arm && !i_item.ignition_on) begin
                n_phase = PH_CHIRP_ARM;
                n_timer = len(i_cfg.chirp_ticks);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ARMED;
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_flash <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_flash <= n_flash;
        end
    end

    // pin image from the state just computed
    logic chirp, loc, fon, home;

    always_comb begin
        chirp = (n_phase == PH_CHIRP_ARM) || (n_phase == PH_CHIRP_DISARM);
        loc   = (n_phase == PH_LOCATE);
        fon   = (n_phase == PH_FLASH_ON);
        home  = (n_mode == MODE_DISARMED) || (n_mode == MODE_PROTECT);

        o_image.horn           = (n_mode == MODE_ALARM) | chirp | loc;
        o_image.parking_lights = chirp | loc | fon;
        o_image.high_beams     = loc | fon;
        o_image.power_enable   = home;
        o_image.gsm_call       = (n_phase == PH_CALL);
        o_image.gsm_hangup     = (n_phase == PH_HANGUP);
        o_image.status_led     = (n_phase == PH_LED_ON) | fon;
        o_image.dome_light     = home & any_open;
        o_image.trunk_light    = home & i_item.trunk_open;
        o_image.hood_light     = home & i_item.hood_open;
        o_image.alarm_mode     = n_mode;
    end

endmodule

`default_nettype wire
